// ===== rtl/mcpt_pkg.sv =====
// shared types and constants for the multibyte code plane table
// no dependencies
`timescale 1ns / 1ps

package mcpt_pkg;

    // plane store geometry and entry layout
    localparam int NUM_PLANES_DEF = 64;
    localparam int BYTE_W         = 8;
    localparam int PLANE_SIZE     = 256;
    localparam int ENTRY_W        = 16;
    localparam int ID_W           = 15;
    localparam int LINK_BIT       = 15;
    localparam int STATUS_W       = 2;

    // operation codes
    localparam logic FUNC_DECODE = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INCONS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // one result item
    typedef struct packed {
        logic                char_valid;
        logic [ID_W-1:0]     char_out;
        logic [STATUS_W-1:0] status;
    } res_t;

endpackage

// ===== rtl/multibyte_code_plane_table.sv =====
// multibyte code plane table: trie of 256-entry planes mapping byte codes to ids
// a taken item's entry is read, decided in S_LOOK and the result put in the output register
// no new item is taken before the last leaves S_LOOK, as its read gives the next address
// while a result waits in the output register one more item is taken, then in_ready stays low
// reset: async active low; then a clearing pass over NUM_PLANES*256 entries (16384 by default)
// with in_ready low; uses mcpt_pkg, mcpt_ram, mcpt_ctrl
`timescale 1ns / 1ps

module multibyte_code_plane_table #(
    parameter int NUM_PLANES = mcpt_pkg::NUM_PLANES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic [mcpt_pkg::BYTE_W-1:0]       code_byte,
    input  logic                              first_byte,
    input  logic                              final_byte,
    input  logic [mcpt_pkg::ID_W-1:0]         char_id,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              char_valid,
    output logic [mcpt_pkg::ID_W-1:0]         char_out,
    output logic [mcpt_pkg::STATUS_W-1:0]     status
);

    localparam int AW    = $clog2(NUM_PLANES) + mcpt_pkg::BYTE_W;
    localparam int DEPTH = NUM_PLANES * mcpt_pkg::PLANE_SIZE;

    logic                           res_valid;
    logic                           res_ready;
    mcpt_pkg::res_t                 res;
    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [mcpt_pkg::ENTRY_W-1:0]   mem_wdata;
    logic                           mem_re;
    logic [AW-1:0]                  mem_raddr;
    logic [mcpt_pkg::ENTRY_W-1:0]   mem_rdata;
    logic                           out_valid_reg, out_valid_next;
    mcpt_pkg::res_t                 out_data_reg;

    // plane store
    mcpt_ram #(
        .WIDTH (mcpt_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer
    mcpt_ctrl #(
        .NUM_PLANES (NUM_PLANES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .code_byte  (code_byte),
        .first_byte (first_byte),
        .final_byte (final_byte),
        .char_id    (char_id),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // output register, refilled as the previous item leaves
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign char_valid = out_data_reg.char_valid;
    assign char_out   = out_data_reg.char_out;
    assign status     = out_data_reg.status;

    // an accepted item blocks the input for the read cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in flight");

    // an accepted item yields a result offered in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> res_valid)
        else $error("no result after an accepted item");

    // a failed insert never reports a decoded id
    a_status_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status != mcpt_pkg::ST_OK) |-> !res.char_valid)
        else $error("error status together with a decoded id");

endmodule

// ===== rtl/mcpt_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module mcpt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds its value when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mcpt_ctrl.sv =====
// sequencer of the plane table: clearing pass, read of one entry per item,
// then decision and write back; uses mcpt_pkg
`timescale 1ns / 1ps

module mcpt_ctrl #(
    parameter int NUM_PLANES = mcpt_pkg::NUM_PLANES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input item
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  func,
    input  logic [mcpt_pkg::BYTE_W-1:0]           code_byte,
    input  logic                                  first_byte,
    input  logic                                  final_byte,
    input  logic [mcpt_pkg::ID_W-1:0]             char_id,
    // result toward the output register
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output mcpt_pkg::res_t                        res,
    // plane store
    output logic                                  mem_we,
    output logic [$clog2(NUM_PLANES)+7:0]         mem_waddr,
    output logic [mcpt_pkg::ENTRY_W-1:0]          mem_wdata,
    output logic                                  mem_re,
    output logic [$clog2(NUM_PLANES)+7:0]         mem_raddr,
    input  logic [mcpt_pkg::ENTRY_W-1:0]          mem_rdata
);

    localparam int PW    = $clog2(NUM_PLANES);
    localparam int AW    = PW + mcpt_pkg::BYTE_W;
    localparam int UW    = $clog2(NUM_PLANES + 1);
    localparam int DEPTH = NUM_PLANES * mcpt_pkg::PLANE_SIZE;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [mcpt_pkg::ENTRY_W-1:0] NP_ENTRY = mcpt_pkg::ENTRY_W'(NUM_PLANES);
    localparam logic [UW-1:0] NP_USED = UW'(NUM_PLANES);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [AW-1:0]              clr_cnt_reg, clr_cnt_next;
    logic [PW-1:0]              walk_reg, walk_next;
    logic [UW-1:0]              used_reg, used_next;
    logic                       func_reg;
    logic                       final_reg;
    logic [mcpt_pkg::ID_W-1:0]  cid_reg;
    logic [AW-1:0]              addr_reg;

    logic                       accept;
    logic [PW-1:0]              start_plane;
    logic                       is_link;
    logic                       is_empty;
    logic [PW-1:0]              link_tgt;
    logic                       do_write;
    logic [mcpt_pkg::ENTRY_W-1:0] wr_entry;
    logic                       do_alloc;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // read address from the current walk, restarted by first_byte
    assign start_plane = first_byte ? '0 : walk_reg;
    assign mem_re      = accept;
    assign mem_raddr   = {start_plane, code_byte};

    // entry decoding
    assign is_link  = mem_rdata[mcpt_pkg::LINK_BIT];
    assign is_empty = (mem_rdata == '0);
    assign link_tgt = ({1'b0, mem_rdata[mcpt_pkg::ID_W-1:0]} < NP_ENTRY)
                      ? mem_rdata[PW-1:0] : '0;

    // decision on the entry read for the held item
    always_comb
    begin
        res            = '0;
        walk_next      = walk_reg;
        do_write       = 1'b0;
        do_alloc       = 1'b0;
        wr_entry       = '0;
        if (func_reg == mcpt_pkg::FUNC_DECODE)
        begin
            if (!is_link)
            begin
                res.char_valid = 1'b1;
                res.char_out   = mem_rdata[mcpt_pkg::ID_W-1:0];
                walk_next      = '0;
            end
            else
            begin
                walk_next = link_tgt;
            end
        end
        else if (final_reg)
        begin
            if (is_link)
            begin
                res.status = mcpt_pkg::ST_INCONS;
            end
            else
            begin
                do_write = 1'b1;
                wr_entry = {1'b0, cid_reg};
            end
            walk_next = '0;
        end
        else
        begin
            if (!is_empty && !is_link)
            begin
                res.status = mcpt_pkg::ST_INCONS;
                walk_next  = '0;
            end
            else if (is_empty)
            begin
                if (used_reg >= NP_USED)
                begin
                    res.status = mcpt_pkg::ST_FULL;
                    walk_next  = '0;
                end
                else
                begin
                    do_write  = 1'b1;
                    do_alloc  = 1'b1;
                    wr_entry  = {1'b1, mcpt_pkg::ID_W'(used_reg)};
                    walk_next = used_reg[PW-1:0];
                end
            end
            else
            begin
                walk_next = link_tgt;
            end
        end
    end

    assign res_valid = (state_reg == S_LOOK);

    // write port: clearing sweep or write back of the held item
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = wr_entry;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (state_reg == S_LOOK)
        begin
            mem_we = do_write && res_ready;
        end
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        used_next    = used_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                    if (do_alloc)
                    begin
                        used_next = used_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            walk_reg    <= '0;
            used_reg    <= UW'(1);
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            used_reg    <= used_next;
            if (state_reg == S_LOOK && res_ready)
            begin
                walk_reg <= walk_next;
            end
        end
    end

    // held item fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            final_reg <= final_byte;
            cid_reg   <= char_id;
            addr_reg  <= mem_raddr;
        end
    end

endmodule
